// ===== design/undirected_edge_list_table_unit_macros.svh =====
// Assertion macros shared by the edge list table RTL.
`ifndef UNDIRECTED_EDGE_LIST_TABLE_UNIT_MACROS_SVH
`define UNDIRECTED_EDGE_LIST_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define UELTU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define UELTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ueltu_pkg.sv =====
// Package with shared types and constants of the edge list table.
`timescale 1ns / 1ps
`default_nettype none
package ueltu_pkg;

  localparam int REQ_W   = 2;
  localparam int VTX_W   = 8;
  localparam int CNT_W   = 7;
  localparam int STAT_W  = 2;
  localparam int NV_W    = 9;
  localparam int ENTRY_W = 2 * VTX_W;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic [NV_W-1:0] NV_RESET = 9'd16;

  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DEGREE = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_VTX = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  edge_total;
    logic [CNT_W-1:0]  degree;
    logic              found;
  } res_t;

endpackage
`default_nettype wire

// ===== design/ueltu_mem.sv =====
// Edge entry memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ueltu_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                        clk,
  input  wire ueltu_pkg::mem_ctl_t         ctl,
  input  wire logic [AW-1:0]               rd_addr,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [ueltu_pkg::ENTRY_W-1:0] wr_data,
  output logic      [ueltu_pkg::ENTRY_W-1:0] rd_data
);
  import ueltu_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== design/ueltu_ctrl.sv =====
// Request sequencer: scans the edge memory, then appends an inserted pair or swaps the last entry into a removed slot.
`timescale 1ns / 1ps
`default_nettype none
`include "undirected_edge_list_table_unit_macros.svh"
module ueltu_ctrl #(
  parameter int MAX_EDGES    = 64,
  parameter int MAX_VERTICES = 256,
  parameter int AW           = 6,
  parameter int CW           = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [ueltu_pkg::NV_W-1:0]    num_vertices,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ueltu_pkg::REQ_W-1:0]   req_type,
  input  wire logic [ueltu_pkg::VTX_W-1:0]   vertex_a,
  input  wire logic [ueltu_pkg::VTX_W-1:0]   vertex_b,
  output ueltu_pkg::mem_ctl_t                mem_ctl,
  output logic [AW-1:0]                      rd_addr,
  output logic [AW-1:0]                      wr_addr,
  output logic [ueltu_pkg::ENTRY_W-1:0]      wr_data,
  input  wire logic [ueltu_pkg::ENTRY_W-1:0] rd_data,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output ueltu_pkg::res_t                    res
);
  import ueltu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_UPDATE, S_MOVE, S_RESULT
  } state_t;

  state_t            state_r, state_nxt;
  logic [REQ_W-1:0]  op_r, op_nxt;
  logic [VTX_W-1:0]  a_r, a_nxt;
  logic [VTX_W-1:0]  b_r, b_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     slot_r, slot_nxt;
  logic              found_r, found_nxt;
  logic [CW-1:0]     deg_r, deg_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  logic              accept;
  logic              a_ok, b_ok, req_ok;
  logic [AW-1:0]     last_idx;
  logic [VTX_W-1:0]  ent_x, ent_y;
  logic              pair_hit, touch, at_last, full;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Vertex limit is the smaller of the register and MAX_VERTICES.
  assign a_ok = (32'(vertex_a) < 32'(num_vertices)) && (32'(vertex_a) < MAX_VERTICES);
  assign b_ok = (32'(vertex_b) < 32'(num_vertices)) && (32'(vertex_b) < MAX_VERTICES);
  assign req_ok = (req_type == REQ_DEGREE) ? a_ok : (a_ok && b_ok);

  assign last_idx = AW'(count_r - CW'(1));
  assign full     = (count_r == CW'(MAX_EDGES));
  assign ent_x    = rd_data[VTX_W-1:0];
  assign ent_y    = rd_data[ENTRY_W-1:VTX_W];
  assign pair_hit = ((ent_x == a_r) && (ent_y == b_r)) || ((ent_x == b_r) && (ent_y == a_r));
  assign touch    = (ent_x == a_r) || (ent_y == a_r);
  assign at_last  = (idx_r == last_idx);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    idx_nxt   = idx_r;
    slot_nxt  = slot_r;
    found_nxt = found_r;
    deg_nxt   = deg_r;
    stat_nxt  = stat_r;
    count_nxt = count_r;
    mem_ctl   = '0;
    rd_addr   = '0;
    wr_addr   = count_r[AW-1:0];
    wr_data   = {b_r, a_r};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = req_type;
          a_nxt     = vertex_a;
          b_nxt     = vertex_b;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          deg_nxt   = '0;
          stat_nxt  = STAT_OK;
          if (!req_ok) begin
            stat_nxt  = STAT_BAD_VTX;
            state_nxt = S_RESULT;
          end else if (count_r == '0) begin
            state_nxt = (req_type == REQ_DEGREE) ? S_RESULT : S_UPDATE;
          end else begin
            mem_ctl.rd_en = 1'b1;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_addr = AW'(idx_r + AW'(1));
        if (op_r == REQ_DEGREE) begin
          deg_nxt = deg_r + CW'(touch);
          if (at_last) begin
            state_nxt = S_RESULT;
          end else begin
            mem_ctl.rd_en = 1'b1;
            idx_nxt       = AW'(idx_r + AW'(1));
          end
        end else if (pair_hit) begin
          found_nxt = 1'b1;
          slot_nxt  = idx_r;
          state_nxt = S_UPDATE;
        end else if (at_last) begin
          state_nxt = S_UPDATE;
        end else begin
          mem_ctl.rd_en = 1'b1;
          idx_nxt       = AW'(idx_r + AW'(1));
        end
      end
      S_UPDATE: begin
        rd_addr   = last_idx;
        state_nxt = S_RESULT;
        if ((op_r == REQ_REMOVE) && found_r) begin
          mem_ctl.rd_en = 1'b1;
          state_nxt     = S_MOVE;
        end else if ((op_r == REQ_INSERT) && !found_r) begin
          if (full) begin
            stat_nxt = STAT_FULL;
          end else begin
            mem_ctl.wr_en = 1'b1;
            count_nxt     = count_r + CW'(1);
          end
        end
      end
      S_MOVE: begin
        // Drop the last entry into the freed slot.
        wr_addr       = slot_r;
        wr_data       = rd_data;
        mem_ctl.wr_en = 1'b1;
        count_nxt     = count_r - CW'(1);
        state_nxt     = S_RESULT;
      end
      S_RESULT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_valid      = (state_r == S_RESULT);
  assign res.found      = found_r;
  assign res.degree     = CNT_W'(deg_r);
  assign res.edge_total = CNT_W'(count_r);
  assign res.status     = stat_r;

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    idx_r   <= idx_nxt;
    slot_r  <= slot_nxt;
    found_r <= found_nxt;
    deg_r   <= deg_nxt;
    stat_r  <= stat_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  `UELTU_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(MAX_EDGES), "edge count above capacity")
  `UELTU_ASSERT_NOW(a_no_rw_clash, mem_ctl.wr_en, !mem_ctl.rd_en, "read and write in one cycle")
  `UELTU_ASSERT_NOW(a_count_step, !$stable(count_r),
                    (count_r == CW'($past(count_r) + CW'(1))) ||
                    (count_r == CW'($past(count_r) - CW'(1))), "edge count jumped")

endmodule
`default_nettype wire

// ===== design/undirected_edge_list_table_unit.sv =====
// Top level of the undirected edge list table.
//
// Keeps up to MAX_EDGES undirected edges (vertex pairs) and serves one request
// at a time on a stream input: adjacency query, insert, remove or degree.
// in_tdata carries req_type, vertex_a and vertex_b; every request gives exactly
// one result on out_tdata: found, degree, edge_total and status.
// cfg_wr_en/cfg_wr_data set num_vertices; write it only while the block is idle.
//
// A request walks the stored entries one per cycle through the edge memory's
// single read port before its result reaches the output register. A matching
// pair stops the scan of a query, insert or remove early; a remove that finds
// its pair adds a move state that writes the last entry, read in the update
// state, into the freed slot. Invalid vertices skip the scan and go straight
// to the result state.
// Throughput: one request in flight; in_tready rises again once the result is
// handed to the output register, so the next request may start while the
// previous result still waits for out_tready.
// Reset (rst_n low, synchronous) empties the table and sets num_vertices to 16;
// memory contents are left as they are and never read before being written.
// A stalled receiver holds out_tvalid and out_tdata; the sequencer then waits
// with its result until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "undirected_edge_list_table_unit_macros.svh"
module undirected_edge_list_table_unit #(
  parameter int MAX_EDGES    = 64,
  parameter int MAX_VERTICES = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // cfg_wr_data: num_vertices
  input  wire logic                                cfg_wr_en,
  input  wire logic [ueltu_pkg::NV_W-1:0]          cfg_wr_data,
  // in_tdata: req_type[1:0], vertex_a[9:2], vertex_b[17:10], zero pad
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [ueltu_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata: found[0], degree[7:1], edge_total[14:8], status[16:15], zero pad
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [ueltu_pkg::OUT_TDATA_W-1:0]        out_tdata
);
  import ueltu_pkg::*;

  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);

  logic [NV_W-1:0]    nv_r;
  mem_ctl_t           mem_ctl;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [ENTRY_W-1:0] wr_data, rd_data;
  logic               res_valid, res_ready;
  res_t               res;
  logic               out_valid_r;
  res_t               out_res_r;

  // Hold the vertex limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= NV_RESET;
    end else if (cfg_wr_en) begin
      nv_r <= cfg_wr_data;
    end
  end

  ueltu_mem #(
    .DEPTH (MAX_EDGES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  ueltu_ctrl #(
    .MAX_EDGES    (MAX_EDGES),
    .MAX_VERTICES (MAX_VERTICES),
    .AW           (AW),
    .CW           (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .num_vertices (nv_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .req_type     (in_tdata[1:0]),
    .vertex_a     (in_tdata[9:2]),
    .vertex_b     (in_tdata[17:10]),
    .mem_ctl      (mem_ctl),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_data      (rd_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // Output register: take a new result whenever the slot is empty or draining.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.status, out_res_r.edge_total,
                       out_res_r.degree, out_res_r.found};

  `UELTU_ASSERT_NEXT(a_out_hold, out_valid_r && !out_tready,
                     out_valid_r && $stable(out_res_r), "stalled result changed")
  `UELTU_ASSERT_NOW(a_status_legal, out_valid_r,
                    (out_res_r.status == STAT_OK) || (out_res_r.status == STAT_BAD_VTX) ||
                    (out_res_r.status == STAT_FULL), "illegal status code")
  `UELTU_ASSERT_NOW(a_bad_vtx_clean, out_valid_r && (out_res_r.status == STAT_BAD_VTX),
                    !out_res_r.found && (out_res_r.degree == '0), "invalid vertex with data")

endmodule
`default_nettype wire
